// ----- src/thresholded_frame_centroid_unit_macros.svh -----
// Assertion macros for the thresholded frame centroid unit.
// Depends on nothing; included by the modules that carry assertions.
`ifndef THRESHOLDED_FRAME_CENTROID_UNIT_MACROS_SVH
`define THRESHOLDED_FRAME_CENTROID_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define TFC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("tfc: implication check failed");
`define TFC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("tfc: next-cycle check failed");
`else
`define TFC_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define TFC_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ----- src/tfc_pkg.sv -----
// Shared widths, register indexes and helpers for the thresholded frame centroid unit.
// Depends on nothing.
package tfc_pkg;

    localparam int PIX_W      = 16;
    localparam int DIM_W      = 11;
    localparam int CNT_W      = 10;
    localparam int TOT_W      = 37;
    localparam int MOM_W      = 47;
    localparam int OUT_W      = 19;
    localparam int FRAC_BITS  = 8;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Quotient bits produced by the divider: one more than the result so that
    // the negative limit can still be told apart from an overflow.
    localparam int QUO_W  = OUT_W + 1;
    localparam int DVD_W  = MOM_W + FRAC_BITS;
    localparam int HI_W   = DVD_W - QUO_W;
    localparam int REM_W  = TOT_W + 1;
    localparam int QCNT_W = $clog2(QUO_W);

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WIDTH     = 2'd1;
    localparam logic [1:0] REG_HEIGHT    = 2'd2;

    localparam logic [DIM_W-1:0] RESET_SIZE = DIM_W'(256);

    localparam logic [OUT_W-1:0] OUT_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_NEG_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [OUT_W-1:0] EMPTY_VAL   = OUT_W'(-(1 <<< FRAC_BITS));

    // A size of zero acts as one; a size above the maximum acts as the maximum.
    function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] raw,
                                                  input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] v;
        begin
            if (raw == '0)
            begin
                v = DIM_W'(1);
            end
            else if (raw > maxv)
            begin
                v = maxv;
            end
            else
            begin
                v = raw;
            end
            return v;
        end
    endfunction

endpackage

// ----- src/thresholded_frame_centroid_unit.sv -----
// Thresholded frame centroid unit: accumulates total and row/column moments per frame.
// A new pixel is taken only in the idle state (one shared multiplier is used for both moments).
// A frame's result follows its last pixel transfer through two 20-step restoring
// divisions on one shared subtractor; an empty frame skips the divisions.
// Reset (rst_n, asynchronous, active low) clears counters and sums and sets the configuration registers to defaults.
// Depends on tfc_pkg and thresholded_frame_centroid_unit_macros.svh.
`include "thresholded_frame_centroid_unit_macros.svh"

module thresholded_frame_centroid_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tfc_pkg::ADDR_W-1:0]          paddr,
    input  logic [tfc_pkg::DATA_W-1:0]          pwdata,
    output logic [tfc_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  logic signed [tfc_pkg::PIX_W-1:0]    pixel_value,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [tfc_pkg::OUT_W-1:0]    center_row,
    output logic signed [tfc_pkg::OUT_W-1:0]    center_col,
    output logic                                frame_empty,
    output logic                                result_saturated
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MAC_ROW  = 3'd1;
    localparam logic [2:0] ST_MAC_COL  = 3'd2;
    localparam logic [2:0] ST_DIV_LOAD = 3'd3;
    localparam logic [2:0] ST_DIV_RUN  = 3'd4;
    localparam logic [2:0] ST_DIV_DONE = 3'd5;
    localparam logic [2:0] ST_OUT      = 3'd6;

    logic [2:0]                          state_reg;
    logic signed [tfc_pkg::PIX_W-1:0]    thr_reg;
    logic [tfc_pkg::DIM_W-1:0]           width_reg;
    logic [tfc_pkg::DIM_W-1:0]           height_reg;
    logic [tfc_pkg::CNT_W-1:0]           row_cnt_reg;
    logic [tfc_pkg::CNT_W-1:0]           col_cnt_reg;
    logic signed [tfc_pkg::TOT_W-1:0]    total_reg;
    logic signed [tfc_pkg::MOM_W-1:0]    row_mom_reg;
    logic signed [tfc_pkg::MOM_W-1:0]    col_mom_reg;
    logic signed [tfc_pkg::PIX_W-1:0]    pix_reg;
    logic                                incl_reg;
    logic                                sel_reg;
    logic                                neg_reg;
    logic                                ovf_reg;
    logic                                empty_reg;
    logic                                sat_reg;
    logic [tfc_pkg::TOT_W-1:0]           den_reg;
    logic [tfc_pkg::REM_W-1:0]           rem_reg;
    logic [tfc_pkg::QUO_W-1:0]           dvd_reg;
    logic [tfc_pkg::QUO_W-1:0]           quo_reg;
    logic [tfc_pkg::QCNT_W-1:0]          qcnt_reg;
    logic [tfc_pkg::OUT_W-1:0]           row_res_reg;
    logic [tfc_pkg::OUT_W-1:0]           col_res_reg;
    logic                                out_valid_reg;
    logic [tfc_pkg::OUT_W-1:0]           out_row_reg;
    logic [tfc_pkg::OUT_W-1:0]           out_col_reg;
    logic                                out_empty_reg;
    logic                                out_sat_reg;

    logic                                cfg_write;
    logic                                pix_accept;
    logic                                out_load;
    logic [tfc_pkg::DIM_W-1:0]           w_eff;
    logic [tfc_pkg::DIM_W-1:0]           h_eff;
    logic                                last_col;
    logic                                last_row;
    logic [tfc_pkg::CNT_W-1:0]           mul_cnt;
    logic signed [tfc_pkg::PIX_W+tfc_pkg::CNT_W:0] prod;
    logic signed [tfc_pkg::MOM_W-1:0]    prod_ext;
    logic signed [tfc_pkg::MOM_W-1:0]    num_sel;
    logic [tfc_pkg::MOM_W-1:0]           num_mag;
    logic [tfc_pkg::TOT_W-1:0]           den_mag;
    logic [tfc_pkg::DVD_W-1:0]           dividend;
    logic                                ovf_now;
    logic [tfc_pkg::REM_W-1:0]           trial;
    logic                                trial_ge;
    logic                                div_sat;
    logic [tfc_pkg::OUT_W-1:0]           div_val;

    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite;
    assign pixel_stall = (state_reg != ST_IDLE);
    assign pix_accept  = pixel_valid && !pixel_stall;
    assign out_load    = (state_reg == ST_OUT) && (!out_valid_reg || !result_stall);

    assign result_valid     = out_valid_reg;
    assign center_row       = out_row_reg;
    assign center_col       = out_col_reg;
    assign frame_empty      = out_empty_reg;
    assign result_saturated = out_sat_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            tfc_pkg::REG_THRESHOLD: prdata = tfc_pkg::DATA_W'(unsigned'(thr_reg));
            tfc_pkg::REG_WIDTH:     prdata = tfc_pkg::DATA_W'(width_reg);
            tfc_pkg::REG_HEIGHT:    prdata = tfc_pkg::DATA_W'(height_reg);
            default:                prdata = '0;
        endcase
    end

    assign w_eff    = tfc_pkg::eff_size(width_reg, tfc_pkg::DIM_W'(tfc_pkg::MAX_WIDTH));
    assign h_eff    = tfc_pkg::eff_size(height_reg, tfc_pkg::DIM_W'(tfc_pkg::MAX_HEIGHT));
    assign last_col = ({1'b0, col_cnt_reg} >= (w_eff - tfc_pkg::DIM_W'(1)));
    assign last_row = ({1'b0, row_cnt_reg} >= (h_eff - tfc_pkg::DIM_W'(1)));

    // The one multiplier serves the row moment first, then the column moment.
    assign mul_cnt  = (state_reg == ST_MAC_ROW) ? row_cnt_reg : col_cnt_reg;
    assign prod     = pix_reg * $signed({1'b0, mul_cnt});
    assign prod_ext = tfc_pkg::MOM_W'(prod);

    // Division works on magnitudes; the sign is put back when the result is clipped.
    assign num_sel  = sel_reg ? col_mom_reg : row_mom_reg;
    assign num_mag  = num_sel[tfc_pkg::MOM_W-1] ? unsigned'(-num_sel) : unsigned'(num_sel);
    assign den_mag  = total_reg[tfc_pkg::TOT_W-1] ? unsigned'(-total_reg)
                                                  : unsigned'(total_reg);
    assign dividend = tfc_pkg::DVD_W'(num_mag) << tfc_pkg::FRAC_BITS;
    assign ovf_now  = tfc_pkg::REM_W'(dividend[tfc_pkg::DVD_W-1:tfc_pkg::QUO_W])
                      >= tfc_pkg::REM_W'(den_mag);

    assign trial    = {rem_reg[tfc_pkg::REM_W-2:0], dvd_reg[tfc_pkg::QUO_W-1]};
    assign trial_ge = (trial >= tfc_pkg::REM_W'(den_reg));

    always_comb
    begin
        if (neg_reg)
        begin
            div_sat = ovf_reg || (quo_reg > tfc_pkg::QUO_W'(tfc_pkg::OUT_NEG_MIN));
            div_val = div_sat ? tfc_pkg::OUT_NEG_MIN
                              : (~quo_reg[tfc_pkg::OUT_W-1:0]) + tfc_pkg::OUT_W'(1);
        end
        else
        begin
            div_sat = ovf_reg || (quo_reg > tfc_pkg::QUO_W'(tfc_pkg::OUT_POS_MAX));
            div_val = div_sat ? tfc_pkg::OUT_POS_MAX : quo_reg[tfc_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= '0;
            width_reg  <= tfc_pkg::RESET_SIZE;
            height_reg <= tfc_pkg::RESET_SIZE;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                tfc_pkg::REG_THRESHOLD: thr_reg    <= signed'(pwdata[tfc_pkg::PIX_W-1:0]);
                tfc_pkg::REG_WIDTH:     width_reg  <= pwdata[tfc_pkg::DIM_W-1:0];
                tfc_pkg::REG_HEIGHT:    height_reg <= pwdata[tfc_pkg::DIM_W-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            total_reg     <= '0;
            row_mom_reg   <= '0;
            col_mom_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pix_accept)
                    begin
                        state_reg <= ST_MAC_ROW;
                    end
                end
                ST_MAC_ROW:
                begin
                    if (incl_reg)
                    begin
                        total_reg   <= total_reg + tfc_pkg::TOT_W'(pix_reg);
                        row_mom_reg <= row_mom_reg + prod_ext;
                    end
                    state_reg <= ST_MAC_COL;
                end
                ST_MAC_COL:
                begin
                    if (incl_reg)
                    begin
                        col_mom_reg <= col_mom_reg + prod_ext;
                    end
                    if (!last_col)
                    begin
                        col_cnt_reg <= col_cnt_reg + tfc_pkg::CNT_W'(1);
                        state_reg   <= ST_IDLE;
                    end
                    else
                    begin
                        col_cnt_reg <= '0;
                        if (!last_row)
                        begin
                            row_cnt_reg <= row_cnt_reg + tfc_pkg::CNT_W'(1);
                            state_reg   <= ST_IDLE;
                        end
                        else
                        begin
                            row_cnt_reg <= '0;
                            state_reg   <= ST_DIV_LOAD;
                        end
                    end
                end
                ST_DIV_LOAD:
                begin
                    state_reg <= (total_reg == '0) ? ST_OUT : ST_DIV_RUN;
                end
                ST_DIV_RUN:
                begin
                    if (qcnt_reg == tfc_pkg::QCNT_W'(tfc_pkg::QUO_W - 1))
                    begin
                        state_reg <= ST_DIV_DONE;
                    end
                end
                ST_DIV_DONE:
                begin
                    state_reg <= sel_reg ? ST_OUT : ST_DIV_LOAD;
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        total_reg   <= '0;
                        row_mom_reg <= '0;
                        col_mom_reg <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers of the pixel pipeline, the shared divider and the result outputs.
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            pix_reg  <= pixel_value;
            incl_reg <= (pixel_value >= thr_reg);
        end

        if (state_reg == ST_MAC_COL)
        begin
            sel_reg <= 1'b0;
            sat_reg <= 1'b0;
        end

        if (state_reg == ST_DIV_LOAD)
        begin
            if (total_reg == '0)
            begin
                row_res_reg <= tfc_pkg::EMPTY_VAL;
                col_res_reg <= tfc_pkg::EMPTY_VAL;
                empty_reg   <= 1'b1;
            end
            else
            begin
                empty_reg <= 1'b0;
            end
            neg_reg  <= num_sel[tfc_pkg::MOM_W-1] ^ total_reg[tfc_pkg::TOT_W-1];
            ovf_reg  <= ovf_now;
            den_reg  <= den_mag;
            rem_reg  <= ovf_now ? '0
                                : tfc_pkg::REM_W'(dividend[tfc_pkg::DVD_W-1:tfc_pkg::QUO_W]);
            dvd_reg  <= dividend[tfc_pkg::QUO_W-1:0];
            quo_reg  <= '0;
            qcnt_reg <= '0;
        end

        if (state_reg == ST_DIV_RUN)
        begin
            rem_reg  <= trial_ge ? (trial - tfc_pkg::REM_W'(den_reg)) : trial;
            dvd_reg  <= {dvd_reg[tfc_pkg::QUO_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[tfc_pkg::QUO_W-2:0], trial_ge};
            qcnt_reg <= qcnt_reg + tfc_pkg::QCNT_W'(1);
        end

        if (state_reg == ST_DIV_DONE)
        begin
            if (sel_reg)
            begin
                col_res_reg <= div_val;
            end
            else
            begin
                row_res_reg <= div_val;
            end
            sat_reg <= sat_reg | div_sat;
            sel_reg <= 1'b1;
        end

        if (out_load)
        begin
            out_row_reg   <= row_res_reg;
            out_col_reg   <= col_res_reg;
            out_empty_reg <= empty_reg;
            out_sat_reg   <= empty_reg ? 1'b0 : sat_reg;
        end
    end

    `TFC_ASSERT_IMP(a_empty_result, clk, rst_n, result_valid && frame_empty, (center_row == tfc_pkg::EMPTY_VAL) && (center_col == tfc_pkg::EMPTY_VAL) && !result_saturated)
    `TFC_ASSERT_IMP(a_rem_below_den, clk, rst_n, state_reg == ST_DIV_RUN, rem_reg < tfc_pkg::REM_W'(den_reg))
    `TFC_ASSERT_NXT(a_accept_starts_mac, clk, rst_n, pix_accept, state_reg == ST_MAC_ROW)
    `TFC_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_load, !(out_valid_reg && result_stall))

endmodule

// ----- tb/tb_thresholded_frame_centroid_unit.sv -----
// Self-checking testbench for thresholded_frame_centroid_unit: streams pixel frames through
// the block and checks each frame centroid against a predictor kept in the bench.
// Depends on tfc_pkg and the thresholded_frame_centroid_unit RTL.
module tb_thresholded_frame_centroid_unit;
    import tfc_pkg::*;

    localparam logic [1:0] REG_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 60;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         RANDOM_ITEMS  = 700;
    localparam longint     OUT_HI        = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint     OUT_LO        = -(longint'(1) << (OUT_W - 1));
    localparam longint     ONE_FIXED     = longint'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [OUT_W-1:0] row;
        logic signed [OUT_W-1:0] col;
        logic                    empty;
        logic                    sat;
    } centroid_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     pixel_valid = 1'b0;
    logic                     pixel_stall;
    logic signed [PIX_W-1:0]  pixel_value = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic signed [OUT_W-1:0]  center_row;
    logic signed [OUT_W-1:0]  center_col;
    logic                     frame_empty;
    logic                     result_saturated;

    logic                     calm = 1'b0;
    logic                     hold_off = 1'b0;
    logic                     pressure_on = 1'b0;
    int                       fault_count = 0;
    int                       cycle_count = 0;

    logic signed [PIX_W-1:0]  pixel_backlog[$];
    centroid_t                centroid_due[$];

    // Mirror of the block's registers and frame accumulators.
    logic signed [PIX_W-1:0]  gate_level = '0;
    logic [DIM_W-1:0]         row_len = RESET_SIZE;
    logic [DIM_W-1:0]         rows_per_frame = RESET_SIZE;
    int                       row_pos = 0;
    int                       col_pos = 0;
    longint                   weight_sum = 0;
    longint                   row_sum = 0;
    longint                   col_sum = 0;

    thresholded_frame_centroid_unit u_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .pixel_valid      (pixel_valid),
        .pixel_stall      (pixel_stall),
        .pixel_value      (pixel_value),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .center_row       (center_row),
        .center_col       (center_col),
        .frame_empty      (frame_empty),
        .result_saturated (result_saturated)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Moment over total in fixed point, truncated toward zero and clipped to the output range.
    function automatic logic signed [OUT_W-1:0] fixed_ratio(input longint num,
                                                            input longint den,
                                                            output bit clipped);
        longint q;
        longint r;
        longint v;
        q = num / den;
        r = num % den;
        clipped = 1'b0;
        if (q > OUT_HI + 1 || q < OUT_LO - 1)
        begin
            clipped = 1'b1;
            v = (q > 0) ? OUT_HI : OUT_LO;
        end
        else
        begin
            v = q * ONE_FIXED + (r * ONE_FIXED) / den;
            if (v > OUT_HI)
            begin
                clipped = 1'b1;
                v = OUT_HI;
            end
            else if (v < OUT_LO)
            begin
                clipped = 1'b1;
                v = OUT_LO;
            end
        end
        return v[OUT_W-1:0];
    endfunction

    task automatic absorb_pixel(input logic signed [PIX_W-1:0] pix);
        int        span_w;
        int        span_h;
        centroid_t res;
        bit        clip_r;
        bit        clip_c;
        span_w = (row_len == 0) ? 1 : ((row_len > MAX_WIDTH) ? MAX_WIDTH : int'(row_len));
        span_h = (rows_per_frame == 0) ? 1 :
                 ((rows_per_frame > MAX_HEIGHT) ? MAX_HEIGHT : int'(rows_per_frame));
        if (pix >= gate_level)
        begin
            weight_sum += longint'(pix);
            row_sum    += longint'(pix) * longint'(row_pos);
            col_sum    += longint'(pix) * longint'(col_pos);
        end
        // A counter at or past its bound wraps, which also covers a bound shrunk mid-frame.
        if (col_pos < span_w - 1)
        begin
            col_pos++;
        end
        else
        begin
            col_pos = 0;
            if (row_pos < span_h - 1)
            begin
                row_pos++;
            end
            else
            begin
                row_pos = 0;
                if (weight_sum == 0)
                begin
                    res.row   = OUT_W'(-ONE_FIXED);
                    res.col   = OUT_W'(-ONE_FIXED);
                    res.empty = 1'b1;
                    res.sat   = 1'b0;
                end
                else
                begin
                    res.row   = fixed_ratio(row_sum, weight_sum, clip_r);
                    res.col   = fixed_ratio(col_sum, weight_sum, clip_c);
                    res.empty = 1'b0;
                    res.sat   = clip_r | clip_c;
                end
                centroid_due.push_back(res);
                weight_sum = 0;
                row_sum    = 0;
                col_sum    = 0;
            end
        end
    endtask

    task automatic report_fault(input string what, input centroid_t want, input centroid_t got);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("%s: expected row %0d col %0d empty %0b sat %0b,",
                     what, want.row, want.col, want.empty, want.sat);
            $display("    got row %0d col %0d empty %0b sat %0b",
                     got.row, got.col, got.empty, got.sat);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_THRESHOLD: gate_level = value[PIX_W-1:0];
            REG_WIDTH:     row_len = value[DIM_W-1:0];
            REG_HEIGHT:    rows_per_frame = value[DIM_W-1:0];
            default:       ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic feed_pixel(input int v);
        pixel_backlog.push_back(v[PIX_W-1:0]);
    endtask

    // Waits until every pixel has gone in and every frame result has come out, then lets the
    // divider run dry so that the registers can be rewritten safely.
    task automatic settle();
        while (pixel_backlog.size() != 0 || pixel_valid || centroid_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [PIX_W-1:0] pick_pixel();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            v = $urandom_range(0, 2000);
        else if (sel < 7)
            v = $urandom;
        else if (sel == 7)
            v = -int'($urandom_range(0, 2000));
        else if (sel == 8)
            v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        else
            v = 0;
        return v[PIX_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] pick_threshold();
        int sel;
        int v;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            v = $urandom;
        else if (sel == 1)
            v = -32768;
        else if (sel == 2)
            v = 32767;
        else
            v = int'($urandom_range(0, 400)) - 100;
        return v[PIX_W-1:0];
    endfunction

    function automatic logic [DIM_W-1:0] pick_size();
        int sel;
        int v;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            v = 0;
        else if (sel == 1)
            v = $urandom_range(0, 2047);
        else if (sel < 4)
            v = $urandom_range(6, 12);
        else
            v = $urandom_range(1, 5);
        return v[DIM_W-1:0];
    endfunction

    always @(posedge clk)
    begin : pixel_driver
        logic taken;
        if (rst_n)
        begin
            taken = pixel_valid && !pixel_stall;
            if (taken)
                absorb_pixel(pixel_value);
            if (!pixel_valid || taken)
            begin
                if (pixel_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 36))
                begin
                    pixel_valid <= 1'b1;
                    pixel_value <= pixel_backlog.pop_front();
                end
                else
                begin
                    pixel_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        centroid_t got;
        centroid_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                got = '{center_row, center_col, frame_empty, result_saturated};
                if (centroid_due.size() == 0)
                begin
                    report_fault("centroid with no frame pending", '0, got);
                end
                else
                begin
                    want = centroid_due.pop_front();
                    if (want !== got)
                        report_fault("centroid mismatch", want, got);
                end
            end
            result_stall <= hold_off || (!calm && $urandom_range(0, 99) < 36);
        end
    end

    // One long hold-off on the result side, so that the block backs up and stalls its input.
    initial
    begin : receiver_hold
        while (!pressure_on)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_thresholded_frame_centroid_unit failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int fed;
        int n;
        int round;
        fed = 0;
        round = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two-pixel frames: clipping both ways, a zero total and an all-zero frame.
        write_reg(REG_THRESHOLD, 32'h0000_8000);
        write_reg(REG_WIDTH, 32'd2);
        write_reg(REG_HEIGHT, 32'd1);
        feed_pixel(32767);
        feed_pixel(-32766);
        feed_pixel(-32768);
        feed_pixel(32767);
        feed_pixel(32767);
        feed_pixel(-32768);
        feed_pixel(5);
        feed_pixel(-5);
        feed_pixel(0);
        feed_pixel(0);
        settle();

        // Zero sizes act as one; the top threshold passes only the largest pixel.
        write_reg(REG_THRESHOLD, 32'h0000_7FFF);
        write_reg(REG_WIDTH, 32'd0);
        write_reg(REG_HEIGHT, 32'd0);
        feed_pixel(32767);
        feed_pixel(32766);
        settle();

        // Oversized frame abandoned part way: shrinking the width and height ends the frame early.
        write_reg(REG_THRESHOLD, 32'd0);
        write_reg(REG_WIDTH, 32'd2047);
        write_reg(REG_HEIGHT, 32'd2047);
        write_reg(REG_UNUSED, 32'h0000_0001);
        feed_pixel(100);
        feed_pixel(200);
        feed_pixel(300);
        settle();
        write_reg(REG_WIDTH, 32'd1);
        write_reg(REG_HEIGHT, 32'd1);
        feed_pixel(400);
        settle();

        // Shrinking the height mid-frame ends the frame at the end of the current row.
        write_reg(REG_WIDTH, 32'd3);
        write_reg(REG_HEIGHT, 32'd4);
        repeat (7) feed_pixel(pick_pixel());
        settle();
        write_reg(REG_HEIGHT, 32'd2);
        repeat (2) feed_pixel(pick_pixel());
        settle();

        // Single-pixel frames under a long receiver hold-off.
        write_reg(REG_THRESHOLD, 32'(pick_threshold()));
        write_reg(REG_WIDTH, 32'd1);
        write_reg(REG_HEIGHT, 32'd1);
        pressure_on <= 1'b1;
        repeat (80) feed_pixel(pick_pixel());
        settle();
        pressure_on <= 1'b0;

        while (fed < RANDOM_ITEMS)
        begin
            write_reg(REG_THRESHOLD, 32'(pick_threshold()));
            write_reg(REG_WIDTH, 32'(pick_size()));
            write_reg(REG_HEIGHT, 32'(pick_size()));
            calm <= (round >= 2) && (round <= 4);
            n = $urandom_range(10, 60);
            repeat (n) feed_pixel(pick_pixel());
            fed += n;
            round++;
            settle();
        end

        if (fault_count == 0)
            $display("tb_thresholded_frame_centroid_unit passed");
        else
            $display("tb_thresholded_frame_centroid_unit failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/tfc_pkg.sv
src/thresholded_frame_centroid_unit.sv
tb/tb_thresholded_frame_centroid_unit.sv
